### hw/rtl/ctg_pkg.sv
`default_nettype none

package ctg_pkg;

	// Defaults for the top-level parameters
	localparam int unsigned SINE_TABLE_DEPTH_DEF = 1024;
	localparam int unsigned COUNT_BITS_DEF       = 16;

	// Entries in each of the two queues, the request queue and the output queue
	localparam int unsigned QUEUE_DEPTH = 2;

	// Envelope full scale (1.0 in Q24), square level (0.6 in Q15), LFSR taps
	localparam logic [24:0] ENV_ONE    = 25'h100_0000;
	localparam logic [14:0] SQUARE_Q15 = 15'd19661;
	localparam logic [15:0] LFSR_TAPS  = 16'hB400;

	typedef enum logic [1:0] {
		WAVE_SINE   = 2'd0,
		WAVE_SQUARE = 2'd1,
		WAVE_NOISE  = 2'd2,
		WAVE_SILENT = 2'd3
	} wave_t;

	typedef enum logic [2:0] {
		REG_START_STEP   = 3'd0,
		REG_SWEEP_STEP   = 3'd1,
		REG_SAMPLE_COUNT = 3'd2,
		REG_ENV_STEP     = 3'd3,
		REG_WAVE_TYPE    = 3'd4,
		REG_VOLUME       = 3'd5,
		REG_NOISE_SEED   = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic [30:0]        start_step;
		logic signed [31:0] sweep_step;
		logic [15:0]        sample_count;
		logic [24:0]        env_step;
		wave_t              wave_type;
		logic [7:0]         volume;
		logic [15:0]        noise_seed;
	} cfg_t;

	// One classified tick, handed from the front end to the datapath
	typedef struct packed {
		logic        playing;
		logic        last;
		logic [31:0] phase;
		logic [24:0] env;
		logic [15:0] lfsr;
	} req_t;

	typedef struct packed {
		logic signed [14:0] sample;
		logic               last;
		logic               playing;
	} res_t;

endpackage

`default_nettype wire

### hw/rtl/chirp_tone_generator.sv
// Channel   Direction  Handshake             Payload
// -------   ---------  --------------------  --------------------------------
// tick      in         push / full           restart
// sample    out        empty / pop           sample, last, playing
// config    in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// One sample per clock sustained while the output queue has room; a tick reaches
// the output through the request queue, the arithmetic pipe and the output queue.
// The rate is set by the pipe, whose widest stage is a 23 x 32 multiply.
// Reset clears the tone state and the configuration to their defaults at once.
// A full output queue freezes the pipe; the tick queue then fills and raises full.
// cfg_ready is always high.

`default_nettype none

module chirp_tone_generator #(
	parameter int unsigned SINE_TABLE_DEPTH = ctg_pkg::SINE_TABLE_DEPTH_DEF,
	parameter int unsigned COUNT_BITS       = ctg_pkg::COUNT_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// tick channel
	input  wire logic        push,
	output logic             full,
	input  wire logic        restart,
	// sample channel
	output logic             empty,
	input  wire logic        pop,
	output logic signed [14:0] sample,
	output logic             last,
	output logic             playing,
	// configuration channel
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);

	import ctg_pkg::*;

	cfg_t cfg_q;

	logic req_push;
	req_t req_w;
	logic req_full;
	logic req_empty;
	logic req_pop;
	req_t req_rd;

	logic res_push;
	res_t res_w;
	logic res_full;
	res_t res_rd;

	// Configuration registers: write on request, ignore unknown indices
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_step   <= '0;
			cfg_q.sweep_step   <= '0;
			cfg_q.sample_count <= 16'd1;
			cfg_q.env_step     <= '0;
			cfg_q.wave_type    <= WAVE_SINE;
			cfg_q.volume       <= 8'd255;
			cfg_q.noise_seed   <= 16'd1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_START_STEP:   cfg_q.start_step   <= cfg_data[30:0];
				REG_SWEEP_STEP:   cfg_q.sweep_step   <= $signed(cfg_data);
				REG_SAMPLE_COUNT: cfg_q.sample_count <= cfg_data[15:0];
				REG_ENV_STEP:     cfg_q.env_step     <= cfg_data[24:0];
				REG_WAVE_TYPE:    cfg_q.wave_type    <= wave_t'(cfg_data[1:0]);
				REG_VOLUME:       cfg_q.volume       <= cfg_data[7:0];
				REG_NOISE_SEED:   cfg_q.noise_seed   <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// Front end: take each tick, step the oscillator state, classify the tick
	// as playing or idle and hand one request to the datapath.
	ctg_front #(
		.COUNT_BITS(COUNT_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.restart  (restart),
		.req_full (req_full),
		.cfg      (cfg_q),
		.req_push (req_push),
		.req      (req_w)
	);

	assign full = req_full;

	// Short queue between the front end and the datapath
	ctg_fifo #(
		.WIDTH($bits(req_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_req_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (req_push),
		.wdata  (req_w),
		.full   (req_full),
		.pop    (req_pop),
		.rdata  (req_rd),
		.empty  (req_empty)
	);

	// Datapath: table lookup, waveform, envelope and gain scaling
	ctg_back #(
		.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (!req_empty),
		.req       (req_rd),
		.req_pop   (req_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res_w),
		.wave_type (cfg_q.wave_type),
		.volume    (cfg_q.volume)
	);

	// Output queue: hold finished samples until the consumer pops them
	ctg_fifo #(
		.WIDTH($bits(res_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_w),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_rd),
		.empty  (empty)
	);

	assign sample  = res_rd.sample;
	assign last    = res_rd.last;
	assign playing = res_rd.playing;

	// The datapath only drains a non-empty tick queue
	a_req_pop_ok: assert property (@(posedge clk) disable iff (!arst_n)
		req_pop |-> !req_empty)
		else $error("datapath popped an empty request queue");

	// A finished sample never overruns the output queue
	a_res_push_ok: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("datapath pushed into a full output queue");

	// The final sample always belongs to a tone
	a_last_playing: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && last) |-> playing)
		else $error("last flagged outside a tone");

	// Idle ticks are silent
	a_idle_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !playing) |-> (sample == '0))
		else $error("non-zero sample while idle");

endmodule

`default_nettype wire

### hw/rtl/ctg_fifo.sv
`default_nettype none

module ctg_fifo #(
	parameter int unsigned WIDTH = $bits(ctg_pkg::res_t),
	parameter int unsigned DEPTH = ctg_pkg::QUEUE_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      rdata,
	output logic                  empty
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == FULL_CNT);
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

### hw/rtl/ctg_front.sv
`default_nettype none

module ctg_front #(
	parameter int unsigned COUNT_BITS = ctg_pkg::COUNT_BITS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire logic          restart,
	input  wire logic          req_full,
	input  wire ctg_pkg::cfg_t cfg,
	output logic               req_push,
	output ctg_pkg::req_t      req
);

	import ctg_pkg::*;

	logic [31:0]           phase_q;
	logic [31:0]           tune_q;
	logic [24:0]           env_q;
	logic [COUNT_BITS-1:0] idx_q;
	logic [15:0]           lfsr_q;
	logic                  active_q;

	logic                  accept;
	logic [COUNT_BITS-1:0] cnt;
	logic [COUNT_BITS-1:0] last_idx;
	logic [31:0]           cur_phase;
	logic [31:0]           cur_tune;
	logic [24:0]           cur_env;
	logic [COUNT_BITS-1:0] cur_idx;
	logic [15:0]           cur_lfsr;
	logic                  cur_act;
	logic                  is_last;
	logic [24:0]           env_next;
	logic [15:0]           lfsr_next;

	always_comb begin
		accept = push && !req_full;

		// A zero length plays as a single sample
		cnt = COUNT_BITS'(cfg.sample_count);
		if (cnt == '0) begin
			cnt = COUNT_BITS'(1);
		end
		last_idx = cnt - COUNT_BITS'(1);

		if (restart) begin
			cur_phase = '0;
			cur_tune  = {1'b0, cfg.start_step};
			cur_env   = ENV_ONE;
			cur_idx   = '0;
			cur_lfsr  = (cfg.noise_seed != '0) ? cfg.noise_seed : 16'd1;
			cur_act   = 1'b1;
		end else begin
			cur_phase = phase_q;
			cur_tune  = tune_q;
			cur_env   = env_q;
			cur_idx   = idx_q;
			cur_lfsr  = lfsr_q;
			cur_act   = active_q;
		end

		is_last   = cur_act && (cur_idx == last_idx);
		env_next  = (cur_env > cfg.env_step) ? cur_env - cfg.env_step : '0;
		lfsr_next = cur_lfsr[0] ? ((cur_lfsr >> 1) ^ LFSR_TAPS) : (cur_lfsr >> 1);

		req.playing = cur_act;
		req.last    = is_last;
		req.phase   = cur_phase;
		req.env     = cur_env;
		req.lfsr    = cur_lfsr;
	end

	assign req_push = accept;

	// Advance the tone once per active tick; an idle tick leaves it alone
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= '0;
			tune_q   <= '0;
			env_q    <= '0;
			idx_q    <= '0;
			lfsr_q   <= 16'd1;
			active_q <= 1'b0;
		end else if (accept && cur_act) begin
			phase_q  <= cur_phase + cur_tune;
			tune_q   <= cur_tune + cfg.sweep_step;
			env_q    <= env_next;
			idx_q    <= cur_idx + COUNT_BITS'(1);
			lfsr_q   <= lfsr_next;
			active_q <= !is_last;
		end
	end

endmodule

`default_nettype wire

### hw/rtl/ctg_back.sv
`default_nettype none

module ctg_back #(
	parameter int unsigned SINE_TABLE_DEPTH = ctg_pkg::SINE_TABLE_DEPTH_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	input  wire ctg_pkg::req_t  req,
	output logic                req_pop,
	input  wire logic           res_full,
	output logic                res_push,
	output ctg_pkg::res_t       res,
	input  wire ctg_pkg::wave_t wave_type,
	input  wire logic [7:0]     volume
);

	import ctg_pkg::*;

	localparam int unsigned IW = $clog2(SINE_TABLE_DEPTH);
	localparam int unsigned PW = IW + 33;
	localparam logic [IW:0] DEPTH_C = SINE_TABLE_DEPTH[IW:0];

	localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	// Reciprocals: 2^24/200, 2^33/500, 2^32/255, each rounded up
	localparam logic [16:0] RECIP_200 = 17'd83887;
	localparam logic [24:0] RECIP_500 = 25'd17179870;
	localparam logic [24:0] RECIP_255 = 25'd16843010;

	// Quarter-wave Taylor sine of a Q32 angle, rounded to Q15
	function automatic logic signed [15:0] sine_q15(input logic [63:0] t);
		logic [1:0]  quad;
		logic [63:0] r;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] p;
		logic [63:0] s;
		quad = t[31:30];
		r = {34'd0, t[29:0]};
		if (quad[0]) begin
			r = Q30_ONE - r;
		end
		x  = (r * HALF_PI_Q30) >> 30;
		x2 = (x * x) >> 30;
		p  = Q30_ONE;
		p  = Q30_ONE - (((x2 * p) >> 30) / 64'd110);
		p  = Q30_ONE - (((x2 * p) >> 30) / 64'd72);
		p  = Q30_ONE - (((x2 * p) >> 30) / 64'd42);
		p  = Q30_ONE - (((x2 * p) >> 30) / 64'd20);
		p  = Q30_ONE - (((x2 * p) >> 30) / 64'd6);
		s  = (x * p) >> 30;
		s  = (s + 64'd16384) >> 15;
		if (s > 64'd32767) begin
			s = 64'd32767;
		end
		return quad[1] ? -$signed(16'(s)) : $signed(16'(s));
	endfunction

	logic signed [15:0] rom_tbl [SINE_TABLE_DEPTH];

	for (genvar g = 0; g < SINE_TABLE_DEPTH; g++) begin : g_rom
		localparam logic [63:0] ANGLE = (64'(g) << 32) / SINE_TABLE_DEPTH;
		localparam logic signed [15:0] ENTRY = sine_q15(ANGLE);
		assign rom_tbl[g] = ENTRY;
	end

	// Pipeline registers
	logic               v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic               play_s1, play_s2, play_s3, play_s4, play_s5, play_s6;
	logic               last_s1, last_s2, last_s3, last_s4, last_s5, last_s6;
	logic [24:0]        env_s1, env_s2, env_s3, env_s4;
	logic [15:0]        lfsr_s1;
	logic [IW-1:0]      idx_s1;
	logic [8:0]         nq_s1;
	logic signed [15:0] sine_s2;
	logic signed [7:0]  n_s2;
	logic               noise_s3;
	logic               neg_s3, neg_s4, neg_s5, neg_s6;
	logic [14:0]        dmag_s3;
	logic [24:0]        nmag_s3;
	logic [14:0]        amag_s4;
	logic [22:0]        m1_s5;
	logic [31:0]        vg_s5;
	logic [22:0]        u_s6;
	res_t               res_s7;

	logic               adv;
	logic [PW-1:0]      idx_prod;
	logic [32:0]        nq_prod;
	logic [16:0]        rem;
	logic signed [25:0] s_ext;
	logic signed [25:0] n_ext;
	logic signed [25:0] nv;
	logic               neg_c;
	logic [14:0]        dmag_c;
	logic [49:0]        q500_prod;
	logic [54:0]        m2;
	logic [47:0]        q255_prod;
	logic [13:0]        mag_out;
	res_t               res_c;

	// Advance the whole pipe unless the finished result cannot leave
	assign adv      = !(v_s7 && res_full);
	assign req_pop  = req_valid && adv;
	assign res_push = v_s7 && !res_full;
	assign res      = res_s7;

	always_comb begin
		idx_prod = PW'(req.phase) * PW'(DEPTH_C);
		nq_prod  = 33'(req.lfsr) * 33'(RECIP_200);

		rem   = 17'(lfsr_s1) - 17'(nq_s1) * 17'd200;

		s_ext = 26'(sine_s2);
		n_ext = 26'(n_s2);
		nv    = s_ext * 26'sd175 + n_ext * 26'sd106496;
		unique case (wave_type)
			WAVE_SINE: begin
				neg_c  = sine_s2[15];
				dmag_c = sine_s2[15] ? 15'(-sine_s2) : 15'(sine_s2);
			end
			WAVE_SQUARE: begin
				neg_c  = !(sine_s2 > 16'sd0);
				dmag_c = SQUARE_Q15;
			end
			WAVE_NOISE: begin
				neg_c  = nv[25];
				dmag_c = '0;
			end
			default: begin
				neg_c  = 1'b0;
				dmag_c = '0;
			end
		endcase

		q500_prod = 50'(nmag_s3) * 50'(RECIP_500);
		m2        = 55'(m1_s5) * 55'(vg_s5);
		q255_prod = 48'(u_s6) * 48'(RECIP_255);
		mag_out   = q255_prod[45:32];

		res_c.playing = play_s6;
		res_c.last    = last_s6;
		if (!play_s6) begin
			res_c.sample = '0;
		end else if (neg_s6) begin
			res_c.sample = -$signed({1'b0, mag_out});
		end else begin
			res_c.sample = $signed({1'b0, mag_out});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s1 <= req_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// table index and noise quotient
			play_s1 <= req.playing;
			last_s1 <= req.last;
			env_s1  <= req.env;
			lfsr_s1 <= req.lfsr;
			idx_s1  <= idx_prod[32 +: IW];
			nq_s1   <= nq_prod[32:24];
			// table read and noise value
			play_s2 <= play_s1;
			last_s2 <= last_s1;
			env_s2  <= env_s1;
			sine_s2 <= rom_tbl[idx_s1];
			n_s2    <= $signed(rem[7:0] - 8'd100);
			// waveform select
			play_s3  <= play_s2;
			last_s3  <= last_s2;
			env_s3   <= env_s2;
			noise_s3 <= (wave_type == WAVE_NOISE);
			neg_s3   <= neg_c;
			dmag_s3  <= dmag_c;
			nmag_s3  <= nv[25] ? 25'(-nv) : 25'(nv);
			// amplitude magnitude
			play_s4 <= play_s3;
			last_s4 <= last_s3;
			env_s4  <= env_s3;
			neg_s4  <= neg_s3;
			amag_s4 <= noise_s3 ? q500_prod[47:33] : dmag_s3;
			// amplitude times volume, envelope times 125 (16000 = 125 * 2^7)
			play_s5 <= play_s4;
			last_s5 <= last_s4;
			neg_s5  <= neg_s4;
			m1_s5   <= 23'(amag_s4) * 23'(volume);
			vg_s5   <= 32'(env_s4) * 32'd125;
			// full product over 2^32
			play_s6 <= play_s5;
			last_s6 <= last_s5;
			neg_s6  <= neg_s5;
			u_s6    <= m2[54:32];
			// over 255, sign restored
			res_s7 <= res_c;
		end
	end

endmodule

`default_nettype wire
